// ----- design/cbd_pkg.sv -----
// cbd_pkg: shared types and constants of the cpu bus decoder
// address map, action codes, decoded operation codes, queue entry and config types
// no dependencies
package cbd_pkg;

	localparam int RAM_DEPTH   = 2048;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);
	localparam int BANK_BYTES  = 16384;
	localparam int BANK_AW     = $clog2(BANK_BYTES);
	localparam int ROM_OFF_W   = 22;
	localparam int BANK_W      = ROM_OFF_W - BANK_AW;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int DIV_STEPS   = 8;

	// input action codes
	localparam logic [1:0] ACT_READ    = 2'd0;
	localparam logic [1:0] ACT_WRITE   = 2'd1;
	localparam logic [1:0] ACT_BUTTONS = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MAPPER_KIND = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_BANKS   = 1'd1;

	// address map
	localparam logic [15:0] ADDR_PPU_BASE = 16'h2000;
	localparam logic [15:0] ADDR_IO_BASE  = 16'h4000;
	localparam logic [15:0] ADDR_DMA      = 16'h4014;
	localparam logic [15:0] ADDR_PAD_ONE  = 16'h4016;
	localparam logic [15:0] ADDR_PAD_TWO  = 16'h4017;
	localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;

	localparam logic [7:0] PAD_OPEN_BUS = 8'h40;

	typedef enum logic [2:0] {
		TGT_RAM  = 3'd0,
		TGT_PPU  = 3'd1,
		TGT_PAD  = 3'd2,
		TGT_ROM  = 3'd3,
		TGT_DMA  = 3'd4,
		TGT_NONE = 3'd5
	} tgt_t;

	typedef enum logic [3:0] {
		OP_NONE_RD,
		OP_NONE_WR,
		OP_RAM_RD,
		OP_RAM_WR,
		OP_PPU_RD,
		OP_PPU_WR,
		OP_DMA,
		OP_PAD_ONE_RD,
		OP_PAD_TWO_RD,
		OP_STROBE,
		OP_ROM_RD,
		OP_ROM_WR,
		OP_BUTTONS
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RAM,
		BK_DIV
	} bk_state_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  value;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       mapper_kind;
		logic [7:0] num_banks;
	} cfg_t;

endpackage

// ----- design/cbd_ifs.sv -----
// cbd_req_if and cbd_rsp_if: valid/ready channels of the cpu bus decoder
// depends on cbd_pkg
interface cbd_req_if
	import cbd_pkg::*;
();
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] bus_address;
	logic [7:0]  write_value;
	logic [7:0]  button_bits;

	modport source(output valid, action, bus_address, write_value, button_bits, input ready);
	modport sink(input valid, action, bus_address, write_value, button_bits, output ready);
endinterface

interface cbd_rsp_if
	import cbd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	tgt_t                 target;
	logic                 is_write;
	logic [7:0]           read_value;
	logic [ROM_OFF_W-1:0] rom_offset;
	logic [2:0]           ppu_register;
	logic [7:0]           forward_value;

	modport source(output valid, target, is_write, read_value, rom_offset, ppu_register,
		forward_value, input ready);
	modport sink(input valid, target, is_write, read_value, rom_offset, ppu_register,
		forward_value, output ready);
endinterface

// ----- design/cbd_front.sv -----
// cbd_front: accepts request items and classifies them into decoded operations
// depends on cbd_pkg and cbd_req_if
module cbd_front
	import cbd_pkg::*;
(
	cbd_req_if.sink req,
	input  logic    clear_busy,
	input  q_stat_t q_stat,
	output logic    push,
	output entry_t  push_entry
);

	op_t op;

	assign req.ready = !q_stat.full && !clear_busy;
	assign push      = req.valid && req.ready;

	always_comb begin
		op = OP_NONE_RD;
		unique case (req.action)
			ACT_READ: begin
				if (req.bus_address < ADDR_PPU_BASE)
					op = OP_RAM_RD;
				else if (req.bus_address < ADDR_IO_BASE)
					op = OP_PPU_RD;
				else if (req.bus_address == ADDR_PAD_ONE)
					op = OP_PAD_ONE_RD;
				else if (req.bus_address == ADDR_PAD_TWO)
					op = OP_PAD_TWO_RD;
				else if (req.bus_address >= ADDR_ROM_BASE)
					op = OP_ROM_RD;
				else
					op = OP_NONE_RD;
			end
			ACT_WRITE: begin
				if (req.bus_address < ADDR_PPU_BASE)
					op = OP_RAM_WR;
				else if (req.bus_address < ADDR_IO_BASE)
					op = OP_PPU_WR;
				else if (req.bus_address == ADDR_DMA)
					op = OP_DMA;
				else if (req.bus_address == ADDR_PAD_ONE)
					op = OP_STROBE;
				else if (req.bus_address >= ADDR_ROM_BASE)
					op = OP_ROM_WR;
				else
					op = OP_NONE_WR;
			end
			ACT_BUTTONS: op = OP_BUTTONS;
			default:     op = OP_NONE_RD;
		endcase
	end

	always_comb begin
		push_entry.op    = op;
		push_entry.addr  = req.bus_address;
		// button updates carry their byte in the same slot as write data
		push_entry.value = (req.action == ACT_BUTTONS) ? req.button_bits : req.write_value;
	end

endmodule

// ----- design/cbd_queue.sv -----
// cbd_queue: short fifo of decoded operations between front and back
// depends on cbd_pkg
module cbd_queue
	import cbd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output entry_t  head,
	output q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head         = slots_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- design/cbd_back.sv -----
// cbd_back: carries out decoded operations: work ram, joypads, bank register, result register
// depends on cbd_pkg and cbd_rsp_if
module cbd_back
	import cbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  q_stat_t q_stat,
	input  entry_t  head,
	output logic    pop,
	output logic    clear_busy,
	cbd_rsp_if.source rsp
);

	localparam int DIV_CW = $clog2(DIV_STEPS);

	bk_state_t state_q, state_d;

	logic [RAM_AW-1:0] clr_q;
	logic [7:0]        buttons_q;
	logic [7:0]        pad_one_q;
	logic [7:0]        pad_two_q;
	logic              strobe_q;
	logic [7:0]        bank_q;
	logic [7:0]        div_val_q;
	logic [7:0]        rem_q;
	logic [DIV_CW-1:0] div_cnt_q;

	logic [7:0] ram_mem [RAM_DEPTH];
	logic [7:0] ram_rd_q;

	logic              can_load, take, div_go, load;
	logic              ram_we, ram_re;
	logic [RAM_AW-1:0] ram_wa;
	logic [7:0]        ram_wd;
	logic [8:0]        div_trial;
	logic [7:0]        rem_next;
	logic [BANK_W-1:0] rom_bank;
	logic [ROM_OFF_W-1:0] rom_off;
	logic              pad_bit;

	tgt_t                 res_target;
	logic                 res_write;
	logic [7:0]           res_read;
	logic [ROM_OFF_W-1:0] res_rom;
	logic [2:0]           res_preg;
	logic [7:0]           res_fwd;

	logic                 rsp_valid_q;
	tgt_t                 target_q;
	logic                 is_write_q;
	logic [7:0]           read_value_q;
	logic [ROM_OFF_W-1:0] rom_offset_q;
	logic [2:0]           ppu_register_q;
	logic [7:0]           forward_value_q;

	assign can_load   = !rsp_valid_q || rsp.ready;
	assign take       = (state_q == BK_IDLE) && !q_stat.empty && can_load;
	assign div_go     = cfg.mapper_kind && (cfg.num_banks != '0);
	assign clear_busy = (state_q == BK_CLEAR);

	// restoring remainder, one dividend bit per cycle
	assign div_trial = {rem_q, div_val_q[7]};
	assign rem_next  = (div_trial >= {1'b0, cfg.num_banks}) ?
		8'(div_trial - {1'b0, cfg.num_banks}) : div_trial[7:0];

	// in switchable mode the upper rom half (address bit 14 set) maps to the last bank
	always_comb begin
		if (head.addr[BANK_AW])
			rom_bank = (cfg.num_banks == '0) ? '0 : BANK_W'(cfg.num_banks - 8'd1);
		else
			rom_bank = BANK_W'(bank_q);
		if (cfg.mapper_kind)
			rom_off = {rom_bank, head.addr[BANK_AW-1:0]};
		else if (cfg.num_banks == 8'd1)
			rom_off = ROM_OFF_W'(head.addr[BANK_AW-1:0]);
		else
			rom_off = ROM_OFF_W'(head.addr[BANK_AW:0]);
	end

	always_comb begin
		if (strobe_q)
			pad_bit = buttons_q[0];
		else if (head.op == OP_PAD_TWO_RD)
			pad_bit = pad_two_q[0];
		else
			pad_bit = pad_one_q[0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_q == RAM_AW'(RAM_DEPTH - 1)) state_d = BK_IDLE;
			BK_IDLE: begin
				if (take) begin
					if (head.op == OP_RAM_RD)
						state_d = BK_RAM;
					else if (head.op == OP_ROM_WR && div_go)
						state_d = BK_DIV;
				end
			end
			BK_RAM: if (can_load) state_d = BK_IDLE;
			BK_DIV: if (div_cnt_q == DIV_CW'(DIV_STEPS - 1)) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load       = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_wa     = head.addr[RAM_AW-1:0];
		ram_wd     = head.value;
		res_target = TGT_NONE;
		res_write  = 1'b0;
		res_read   = '0;
		res_rom    = '0;
		res_preg   = '0;
		res_fwd    = '0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = '0;
			end
			BK_IDLE: begin
				if (take) begin
					pop  = 1'b1;
					load = (head.op != OP_RAM_RD);
					case (head.op) inside
						OP_NONE_WR: res_write = 1'b1;
						OP_RAM_RD:  ram_re = 1'b1;
						OP_RAM_WR: begin
							ram_we     = 1'b1;
							res_target = TGT_RAM;
							res_write  = 1'b1;
						end
						OP_PPU_RD: begin
							res_target = TGT_PPU;
							res_preg   = head.addr[2:0];
						end
						OP_PPU_WR: begin
							res_target = TGT_PPU;
							res_write  = 1'b1;
							res_preg   = head.addr[2:0];
							res_fwd    = head.value;
						end
						OP_DMA: begin
							res_target = TGT_DMA;
							res_write  = 1'b1;
							res_fwd    = head.value;
						end
						OP_PAD_ONE_RD, OP_PAD_TWO_RD: begin
							res_target = TGT_PAD;
							res_read   = PAD_OPEN_BUS | {7'd0, pad_bit};
						end
						OP_STROBE: begin
							res_target = TGT_PAD;
							res_write  = 1'b1;
						end
						OP_ROM_RD: begin
							res_target = TGT_ROM;
							res_rom    = rom_off;
						end
						OP_ROM_WR: begin
							res_target = TGT_ROM;
							res_write  = 1'b1;
						end
						default: ;
					endcase
				end
			end
			BK_RAM: begin
				if (can_load) begin
					load       = 1'b1;
					res_target = TGT_RAM;
					res_read   = ram_rd_q;
				end
			end
			BK_DIV: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_we)
			ram_mem[ram_wa] <= ram_wd;
		if (ram_re)
			ram_rd_q <= ram_mem[head.addr[RAM_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			buttons_q <= '0;
			pad_one_q <= '0;
			pad_two_q <= '0;
			strobe_q  <= 1'b0;
			bank_q    <= '0;
			div_val_q <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (take) begin
				case (head.op)
					OP_PAD_ONE_RD: if (!strobe_q) pad_one_q <= {1'b1, pad_one_q[7:1]};
					OP_PAD_TWO_RD: if (!strobe_q) pad_two_q <= {1'b1, pad_two_q[7:1]};
					OP_STROBE: begin
						// reload on a rising strobe or while it was held
						if (head.value[0] || strobe_q) begin
							pad_one_q <= buttons_q;
							pad_two_q <= buttons_q;
						end
						strobe_q <= head.value[0];
					end
					OP_BUTTONS: begin
						buttons_q <= head.value;
						pad_one_q <= head.value;
						pad_two_q <= head.value;
					end
					OP_ROM_WR: begin
						if (div_go) begin
							div_val_q <= head.value;
							rem_q     <= '0;
							div_cnt_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == BK_DIV) begin
				div_val_q <= {div_val_q[6:0], 1'b0};
				rem_q     <= rem_next;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_CW'(DIV_STEPS - 1))
					bank_q <= rem_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			target_q        <= res_target;
			is_write_q      <= res_write;
			read_value_q    <= res_read;
			rom_offset_q    <= res_rom;
			ppu_register_q  <= res_preg;
			forward_value_q <= res_fwd;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.target        = target_q;
	assign rsp.is_write      = is_write_q;
	assign rsp.read_value    = read_value_q;
	assign rsp.rom_offset    = rom_offset_q;
	assign rsp.ppu_register  = ppu_register_q;
	assign rsp.forward_value = forward_value_q;

endmodule

// ----- design/console_cpu_bus_decoder.sv -----
// console_cpu_bus_decoder: cpu bus decoder with work ram, joypads and program bank mapper
// depends on cbd_pkg, cbd_ifs, cbd_front, cbd_queue, cbd_back
//
// req carries one item per bus read, bus write or button update; rsp returns one
// result item for each, in order. Both are valid/ready channels. cfg_we, cfg_index
// and cfg_data write the mapper kind and the program bank count; write them only
// while the block is idle.
// A request item is written into the operation queue at the edge that accepts it.
// The back end takes it from the queue head and loads the result register when that
// register is empty or being read; rsp.valid comes from it. Work ram reads first pass
// through the registered ram read. A bank write in switchable mode with a nonzero bank
// count is followed by a remainder step (one dividend bit per cycle) before the next
// item runs; meanwhile the queue still accepts request items.
// After reset the work ram is swept to zero, one byte per cycle, over all 2048 bytes;
// req.ready stays low during the sweep while configuration writes are still taken.
// When rsp is stalled the result register holds, the queue fills, and req.ready
// drops once the queue is full.
module console_cpu_bus_decoder
	import cbd_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cbd_req_if.sink                req,
	cbd_rsp_if.source              rsp
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	entry_t  push_entry;
	entry_t  head;
	logic    push;
	logic    pop;
	logic    clear_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_kind <= 1'b0;
			cfg_q.num_banks   <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAPPER_KIND: cfg_q.mapper_kind <= cfg_data[0];
				REG_NUM_BANKS:   cfg_q.num_banks   <= cfg_data;
				default: ;
			endcase
		end
	end

	cbd_front u_front (
		.req        (req),
		.clear_busy (clear_busy),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	cbd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	cbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.rsp        (rsp)
	);

endmodule

// ----- tb/sv/console_cpu_bus_decoder_tb.sv -----
// console_cpu_bus_decoder_tb: self-checking bench for the cpu bus decoder
// predicts every result item from its own copy of ram, joypad and bank state
// depends on cbd_pkg, cbd_req_if, cbd_rsp_if and console_cpu_bus_decoder
module console_cpu_bus_decoder_tb;
	import cbd_pkg::*;

	localparam logic [1:0]  ACT_UNUSED      = 2'd3;
	localparam logic [15:0] ADDR_RAM_TOP    = 16'h1FFF;
	localparam logic [15:0] ADDR_PPU_TOP    = 16'h3FFF;
	localparam logic [15:0] ADDR_IO_TOP     = 16'h7FFF;
	localparam logic [15:0] ADDR_FIXED_BANK = 16'hC000;
	localparam logic [15:0] ADDR_TOP        = 16'hFFFF;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 120;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] bus_address;
		logic [7:0]  write_value;
		logic [7:0]  button_bits;
	} bus_item_t;

	typedef struct packed {
		tgt_t                 target;
		logic                 is_write;
		logic [7:0]           read_value;
		logic [ROM_OFF_W-1:0] rom_offset;
		logic [2:0]           ppu_register;
		logic [7:0]           forward_value;
	} bus_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	cbd_req_if req_ch();
	cbd_rsp_if rsp_ch();

	console_cpu_bus_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predicted block state and mapping
	logic [7:0] ram_image [RAM_DEPTH];
	logic [7:0] button_state;
	logic [7:0] pad_one_bits;
	logic [7:0] pad_two_bits;
	logic       strobe_on;
	logic [7:0] bank_select;
	logic       map_switchable;
	logic [7:0] bank_total;

	bus_result_t pending_decodes[$];
	int          mismatches  = 0;
	int          cycle_count = 0;
	int          stall_left  = 0;
	bit          quiet       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL console_cpu_bus_decoder");
		$finish;
	end

	function automatic logic [ROM_OFF_W-1:0] rom_offset_for(input logic [15:0] a);
		logic [7:0] bank;
		if (!map_switchable) begin
			// a single bank shows up in both halves of the rom window
			if (bank_total == 8'd1)
				return {8'd0, a[13:0]};
			return {7'd0, a[14:0]};
		end
		if (a < ADDR_FIXED_BANK)
			bank = bank_select;
		else if (bank_total == 8'd0)
			bank = 8'd0;
		else
			bank = bank_total - 8'd1;
		return {bank, a[13:0]};
	endfunction

	function automatic logic [7:0] shift_out_pad(input logic second);
		logic b;
		if (strobe_on) begin
			b = button_state[0];
		end else if (second) begin
			b = pad_two_bits[0];
			pad_two_bits = {1'b1, pad_two_bits[7:1]};
		end else begin
			b = pad_one_bits[0];
			pad_one_bits = {1'b1, pad_one_bits[7:1]};
		end
		return PAD_OPEN_BUS | {7'd0, b};
	endfunction

	function automatic bus_result_t decode_access(input bus_item_t it);
		bus_result_t r;
		logic [15:0] a;
		r = '0;
		r.target = TGT_NONE;
		a = it.bus_address;
		case (it.action)
			ACT_READ: begin
				if (a < ADDR_PPU_BASE) begin
					r.target = TGT_RAM;
					r.read_value = ram_image[a[RAM_AW-1:0]];
				end else if (a < ADDR_IO_BASE) begin
					r.target = TGT_PPU;
					r.ppu_register = a[2:0];
				end else if (a == ADDR_PAD_ONE) begin
					r.target = TGT_PAD;
					r.read_value = shift_out_pad(1'b0);
				end else if (a == ADDR_PAD_TWO) begin
					r.target = TGT_PAD;
					r.read_value = shift_out_pad(1'b1);
				end else if (a >= ADDR_ROM_BASE) begin
					r.target = TGT_ROM;
					r.rom_offset = rom_offset_for(a);
				end
			end
			ACT_WRITE: begin
				r.is_write = 1'b1;
				if (a < ADDR_PPU_BASE) begin
					r.target = TGT_RAM;
					ram_image[a[RAM_AW-1:0]] = it.write_value;
				end else if (a < ADDR_IO_BASE) begin
					r.target = TGT_PPU;
					r.ppu_register = a[2:0];
					r.forward_value = it.write_value;
				end else if (a == ADDR_DMA) begin
					r.target = TGT_DMA;
					r.forward_value = it.write_value;
				end else if (a == ADDR_PAD_ONE) begin
					r.target = TGT_PAD;
					// reload on a rising strobe and while it is held or falling
					if (it.write_value[0] || strobe_on) begin
						pad_one_bits = button_state;
						pad_two_bits = button_state;
					end
					strobe_on = it.write_value[0];
				end else if (a >= ADDR_ROM_BASE) begin
					r.target = TGT_ROM;
					if (map_switchable && bank_total != 8'd0)
						bank_select = it.write_value % bank_total;
				end
			end
			ACT_BUTTONS: begin
				button_state = it.button_bits;
				pad_one_bits = it.button_bits;
				pad_two_bits = it.button_bits;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		bus_item_t   taken;
		bus_result_t want;
		bus_result_t seen;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			taken = {req_ch.action, req_ch.bus_address, req_ch.write_value,
				req_ch.button_bits};
			pending_decodes.push_back(decode_access(taken));
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen = {rsp_ch.target, rsp_ch.is_write, rsp_ch.read_value, rsp_ch.rom_offset,
				rsp_ch.ppu_register, rsp_ch.forward_value};
			if (pending_decodes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("cycle %0d: result item with nothing pending", cycle_count);
			end else begin
				want = pending_decodes.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("cycle %0d: expected tgt %0d wr %0b rd %02h rom %06h ",
							cycle_count, want.target, want.is_write, want.read_value,
							want.rom_offset,
							"reg %0d fwd %02h, ", want.ppu_register, want.forward_value,
							"got tgt %0d wr %0b rd %02h rom %06h ",
							seen.target, seen.is_write, seen.read_value, seen.rom_offset,
							"reg %0d fwd %02h", seen.ppu_register, seen.forward_value);
				end
			end
		end
	end

	// result side: a fresh random stall after each accepted item, none while quiet
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			stall_left = quiet ? 0 : $urandom_range(0, 3);
			rsp_ch.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_ch.ready <= (stall_left == 0);
		end
	end

	function automatic bus_item_t bus_op(input logic [1:0] action, input logic [15:0] a,
		input logic [7:0] value, input logic [7:0] bits);
		bus_item_t it;
		it.action = action;
		it.bus_address = a;
		it.write_value = value;
		it.button_bits = bits;
		return it;
	endfunction

	function automatic logic [15:0] near_bounds(input logic [15:0] lo, input logic [15:0] hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_pad();
		return $urandom_range(0, 1) ? ADDR_PAD_TWO : ADDR_PAD_ONE;
	endfunction

	function automatic bus_item_t random_access();
		bus_item_t it;
		int pick;
		it = bus_op($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 16'($urandom),
			pick_byte(), pick_byte());
		pick = $urandom_range(0, 99);
		if (pick < 25)
			it.bus_address = near_bounds(16'h0000, ADDR_RAM_TOP);
		else if (pick < 35)
			it.bus_address = near_bounds(ADDR_PPU_BASE, ADDR_PPU_TOP);
		else if (pick < 45)
			it.bus_address = pick_pad();
		else if (pick < 50)
			it.action = ACT_BUTTONS;
		else if (pick < 55)
			it.bus_address = ADDR_DMA;
		else if (pick < 85)
			it.bus_address = near_bounds(ADDR_ROM_BASE, ADDR_TOP);
		else if (pick < 95)
			it.bus_address = near_bounds(ADDR_IO_BASE, ADDR_IO_TOP);
		else if (pick < 99)
			it.action = 2'($urandom_range(0, 2));
		else
			it.action = ACT_UNUSED;
		return it;
	endfunction

	task automatic send_item(input bus_item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= it.action;
		req_ch.bus_address <= it.bus_address;
		req_ch.write_value <= it.write_value;
		req_ch.button_bits <= it.button_bits;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic wait_for_results(input int settle);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_decodes.size() != 0) @(posedge clk);
		// bank writes keep the remainder step busy after their result
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_mapping(input logic kind, input logic [7:0] count);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAPPER_KIND;
		cfg_data <= CFG_DATA_W'(kind);
		@(posedge clk);
		cfg_index <= REG_NUM_BANKS;
		cfg_data <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_switchable = kind;
		bank_total = count;
	endtask

	// load buttons, pulse the strobe with one read while it is high, then clock bits out of one pad or the other
	task automatic send_pad_sequence(output int sent);
		int reads;
		reads = $urandom_range(6, 10);
		send_item(bus_op(ACT_BUTTONS, 16'($urandom), 8'h00, pick_byte()));
		send_item(bus_op(ACT_WRITE, ADDR_PAD_ONE, {7'($urandom), 1'b1}, 8'h00));
		send_item(bus_op(ACT_READ, pick_pad(), 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_PAD_ONE, {7'($urandom), 1'b0}, 8'h00));
		repeat (reads) send_item(bus_op(ACT_READ, pick_pad(), 8'h00, 8'h00));
		sent = reads + 4;
	endtask

	task automatic run_phase(input logic kind, input logic [7:0] count, input int n);
		int sent;
		int burst;
		wait_for_results(SETTLE_CYCLES);
		set_mapping(kind, count);
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_pad_sequence(burst);
				sent += burst;
			end else begin
				send_item(random_access());
				sent++;
			end
		end
	endtask

	task automatic test_reset_values();
		send_item(bus_op(ACT_READ, 16'h0000, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_PAD_ONE, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_TOP, 8'h00, 8'h00));
	endtask

	task automatic test_address_map();
		send_item(bus_op(ACT_WRITE, 16'h0000, 8'hFF, 8'h00));
		send_item(bus_op(ACT_READ, 16'h1800, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_RAM_TOP, 8'h5A, 8'hFF));
		send_item(bus_op(ACT_READ, 16'h07FF, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_PPU_BASE, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_PPU_TOP, 8'hA5, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_DMA, 8'h02, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_DMA, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_PAD_TWO, 8'h33, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_IO_TOP, 8'h00, 8'h00));
		// unused action code must leave ram alone
		send_item(bus_op(ACT_UNUSED, 16'h0000, 8'h11, 8'hFF));
		send_item(bus_op(ACT_READ, 16'h0000, 8'h00, 8'h00));
	endtask

	task automatic test_joypads();
		send_item(bus_op(ACT_BUTTONS, 16'h0000, 8'h00, 8'hA5));
		send_item(bus_op(ACT_READ, ADDR_PAD_ONE, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_PAD_ONE, 8'h01, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_PAD_TWO, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_PAD_ONE, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_PAD_ONE, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_PAD_ONE, 8'h00, 8'h00));
		send_item(bus_op(ACT_BUTTONS, 16'h0000, 8'h00, 8'h00));
	endtask

	task automatic test_bank_mapping();
		wait_for_results(SETTLE_CYCLES);
		set_mapping(1'b1, 8'd255);
		send_item(bus_op(ACT_WRITE, ADDR_TOP, 8'hFE, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_ROM_BASE, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_TOP, 8'h00, 8'h00));
		send_item(bus_op(ACT_WRITE, ADDR_ROM_BASE, 8'hFF, 8'h00));
		send_item(bus_op(ACT_READ, 16'hBFFF, 8'h00, 8'h00));
		send_item(bus_op(ACT_READ, ADDR_FIXED_BANK, 8'h00, 8'h00));
	endtask

	task automatic test_flow_control();
		wait_for_results(SETTLE_CYCLES);
		set_mapping(1'b1, 8'd16);
		quiet = 1'b1;
		repeat (PHASE_ITEMS / 2) send_item(random_access());
		// hold the sender until the queue has emptied
		wait_for_results(0);
		quiet = 1'b0;
		repeat (PHASE_ITEMS / 2) send_item(random_access());
	endtask

	task automatic test_random_traffic();
		run_phase(1'b0, 8'd1, PHASE_ITEMS);
		run_phase(1'b0, 8'd255, PHASE_ITEMS);
		run_phase(1'b1, 8'd255, PHASE_ITEMS);
		run_phase(1'b1, 8'd1, PHASE_ITEMS);
		run_phase(1'b1, 8'd0, PHASE_ITEMS);
		run_phase(1'b0, 8'd0, PHASE_ITEMS);
		run_phase(1'b1, 8'($urandom_range(2, 254)), PHASE_ITEMS);
		run_phase(1'b1, 8'd3, PHASE_ITEMS);
		run_phase(1'b0, 8'd2, PHASE_ITEMS);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAPPER_KIND;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_READ;
		req_ch.bus_address = '0;
		req_ch.write_value = '0;
		req_ch.button_bits = '0;
		rsp_ch.ready = 1'b1;
		for (int i = 0; i < RAM_DEPTH; i++)
			ram_image[i] = 8'h00;
		button_state = 8'h00;
		pad_one_bits = 8'h00;
		pad_two_bits = 8'h00;
		strobe_on = 1'b0;
		bank_select = 8'h00;
		map_switchable = 1'b0;
		bank_total = 8'd2;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_address_map();
		test_joypads();
		test_bank_mapping();
		test_flow_control();
		test_random_traffic();
		wait_for_results(SETTLE_CYCLES);
		mismatches += pending_decodes.size();
		if (mismatches == 0)
			$display("PASS console_cpu_bus_decoder");
		else
			$display("FAIL console_cpu_bus_decoder");
		$finish;
	end

endmodule
